[rtl/drpi_pkg.sv]
// ----------------------------------------------------------------------------
// drpi_pkg: shared types and constants for the pose integrator
// Fixed field widths, Q30 trig constants, arctangent table, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package drpi_pkg;

	// Fixed field widths
	localparam int DATA_W = 32;
	localparam int STEP_W = 21;

	// CORDIC datapath widths (Q30 angles and vector components)
	localparam int ANG_W      = 34;
	localparam int MUL_W      = 34;
	localparam int SUM_W      = 48;
	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = 5;

	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	localparam ang_t CORDIC_K    = 34'sd652032874;
	localparam ang_t TWO_PI_Q30  = 34'sd6746518852;
	localparam ang_t PI_Q30      = 34'sd3373259426;
	localparam ang_t HALF_PI_Q30 = 34'sd1686629713;

	// Truncated arctangent of 2^-i in Q30
	function automatic ang_t atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		ang_t a;
		unique case (idx)
			5'd0: a = 34'sh03243F6A8;
			5'd1: a = 34'sh01DAC6705;
			5'd2: a = 34'sh00FADBAFC;
			5'd3: a = 34'sh007F56EA6;
			5'd4: a = 34'sh003FEAB76;
			5'd5: a = 34'sh001FFD55B;
			5'd6: a = 34'sh000FFFAAA;
			5'd7: a = 34'sh0007FFF55;
			5'd8: a = 34'sh0003FFFEA;
			5'd9: a = 34'sh0001FFFFD;
			5'd10: a = 34'sh0000FFFFF;
			5'd11: a = 34'sh00007FFFF;
			5'd12: a = 34'sh00003FFFF;
			5'd13: a = 34'sh00001FFFF;
			5'd14: a = 34'sh00000FFFF;
			5'd15: a = 34'sh000007FFF;
			5'd16: a = 34'sh000003FFF;
			5'd17: a = 34'sh000001FFF;
			5'd18: a = 34'sh000000FFF;
			5'd19: a = 34'sh0000007FF;
			5'd20: a = 34'sh0000003FF;
			5'd21: a = 34'sh0000001FF;
			5'd22: a = 34'sh0000000FF;
			5'd23: a = 34'sh00000007F;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Clamp a wide signed sum to the 32-bit signed range
	function automatic word_t sat32(input sum_t v);
		word_t r;
		if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/dead_reckoning_pose_integrator_core.sv]
// On the first tick after reset the start pose is loaded and the block goes to
// ST_DONE, which registers the result once the output register is free. Later
// ticks run the heading reduction loop, the two fold states, the CORDIC loop and
// six passes of the one multiplier before ST_DONE; no new tick is taken meanwhile.
// Reset (arst_n low, asynchronous) clears the pose, tick count and start flag
// and loads step_time with 0.1 s.
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator_core: unicycle Euler pose integrator
// Reduces the heading modulo 2*pi, runs an iterative CORDIC for cos/sin and
// forms all products on one shared multiplier; sums saturate to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_reckoning_pose_integrator_core #(
	parameter int FRAC_BITS       = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr_en,
	input  wire logic [drpi_pkg::STEP_W-1:0]         cfg_wr_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [drpi_pkg::DATA_W-1:0]  lin_vel,
	input  wire logic signed [drpi_pkg::DATA_W-1:0]  ang_vel,
	input  wire logic signed [drpi_pkg::DATA_W-1:0]  start_x,
	input  wire logic signed [drpi_pkg::DATA_W-1:0]  start_y,
	input  wire logic signed [drpi_pkg::DATA_W-1:0]  start_heading,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [drpi_pkg::DATA_W-1:0]       pos_x,
	output logic signed [drpi_pkg::DATA_W-1:0]       pos_y,
	output logic signed [drpi_pkg::DATA_W-1:0]       heading,
	output logic [drpi_pkg::DATA_W-1:0]              tick_index
);

	import drpi_pkg::*;

	localparam int SHIFT    = 30 - FRAC_BITS;
	localparam int RED_W    = 33 + SHIFT;
	localparam int K_W      = $clog2(SHIFT);
	localparam int N_ITER   = (TRIG_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS;
	localparam int PROD_W   = 2 * MUL_W;
	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(((1 << FRAC_BITS) + 5) / 10);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD_A,
		ST_FOLD_B,
		ST_CORDIC,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_MUL5,
		ST_DONE
	} state_t;

	typedef logic signed [MUL_W-1:0]  mul_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Shift right with rounding half away from zero
	function automatic prod_t rnd_shr(input prod_t p, input int unsigned s);
		prod_t half;
		prod_t acc;
		half = PROD_W'(1) << (s - 1);
		acc  = p + half - PROD_W'(p[PROD_W-1]);
		return acc >>> s;
	endfunction

	// control state
	state_t               state_q;
	logic                 started_q;
	word_t                cur_x_q, cur_y_q, cur_heading_q;
	logic [DATA_W-1:0]    tick_q;
	logic [STEP_W-1:0]    step_time_q;
	logic [K_W-1:0]       k_q;
	logic [ATAN_IDX_W-1:0] i_q;
	logic                 out_valid_q;
	word_t                pos_x_q, pos_y_q, heading_q;
	logic [DATA_W-1:0]    tick_index_q;

	// datapath registers
	mul_t                 v_q, w_q, tc_q, ts_q, dt_q;
	logic [RED_W-1:0]     r_q;
	ang_t                 z_q, x_q, y_q;
	logic                 flip_q;
	prod_t                prod_q;

	// combinational datapath
	logic                 in_fire;
	logic [RED_W-1:0]     red_init, red_step;
	logic [RED_W:0]       red_diff;
	ang_t                 r_lo, z_a, z_b, x_sh, y_sh, atan_i;
	logic                 flip_b;
	ang_t                 cos_v, sin_v;
	mul_t                 mul_a, mul_b;
	prod_t                rnd_hi, rnd_lo;
	sum_t                 dpos, sum_x, sum_y, sum_h;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// heading reduction: offset by a multiple of 2*pi, then restoring subtract
	assign red_init = (RED_W'(cur_heading_q) << SHIFT) + (RED_W'(TWO_PI_Q30) << (SHIFT - 1));
	assign red_step = RED_W'(TWO_PI_Q30) << k_q;
	assign red_diff = {1'b0, r_q} - {1'b0, red_step};

	// fold into [-pi/2, pi/2]
	always_comb begin
		r_lo   = ang_t'(r_q[ANG_W-1:0]);
		z_a    = (r_lo > PI_Q30) ? r_lo - TWO_PI_Q30 : r_lo;
		z_b    = z_q;
		flip_b = 1'b0;
		if (z_q > HALF_PI_Q30) begin
			z_b    = z_q - PI_Q30;
			flip_b = 1'b1;
		end else if (z_q < -HALF_PI_Q30) begin
			z_b    = z_q + PI_Q30;
			flip_b = 1'b1;
		end
	end

	// CORDIC micro-rotation terms
	assign x_sh   = x_q >>> i_q;
	assign y_sh   = y_q >>> i_q;
	assign atan_i = atan_q30(i_q);
	assign cos_v  = flip_q ? -x_q : x_q;
	assign sin_v  = flip_q ? -y_q : y_q;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MUL0: begin
				mul_a = v_q;
				mul_b = cos_v;
			end
			ST_MUL1: begin
				mul_a = v_q;
				mul_b = sin_v;
			end
			ST_MUL2: begin
				mul_a = tc_q;
				mul_b = dt_q;
			end
			ST_MUL3: begin
				mul_a = ts_q;
				mul_b = dt_q;
			end
			default: begin
				mul_a = w_q;
				mul_b = dt_q;
			end
		endcase
	end

	// rounding and saturating sums on the previous product
	assign rnd_hi = rnd_shr(prod_q, 30);
	assign rnd_lo = rnd_shr(prod_q, FRAC_BITS);
	assign dpos   = rnd_lo[SUM_W-1:0];
	assign sum_x  = SUM_W'(cur_x_q) + dpos;
	assign sum_y  = SUM_W'(cur_y_q) + dpos;
	assign sum_h  = SUM_W'(cur_heading_q) + dpos;

	// datapath: operands, reduction, CORDIC, products
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					v_q  <= MUL_W'(lin_vel);
					w_q  <= MUL_W'(ang_vel);
					dt_q <= mul_t'(MUL_W'(step_time_q));
					r_q  <= red_init;
				end
			end
			ST_REDUCE: begin
				if (!red_diff[RED_W]) begin
					r_q <= red_diff[RED_W-1:0];
				end
			end
			ST_FOLD_A: begin
				z_q <= z_a;
			end
			ST_FOLD_B: begin
				z_q    <= z_b;
				flip_q <= flip_b;
				x_q    <= CORDIC_K;
				y_q    <= '0;
			end
			ST_CORDIC: begin
				if (!z_q[ANG_W-1]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_i;
				end
			end
			ST_MUL1: begin
				tc_q <= rnd_hi[MUL_W-1:0];
			end
			ST_MUL2: begin
				ts_q <= rnd_hi[MUL_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer, pose state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			started_q     <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			cur_heading_q <= '0;
			tick_q        <= '0;
			step_time_q   <= STEP_RST;
			k_q           <= '0;
			i_q           <= '0;
			out_valid_q   <= 1'b0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_q     <= '0;
			tick_index_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				step_time_q <= cfg_wr_data;
			end
			// drop the result once the transaction completes, unless a new one loads
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!started_q) begin
							started_q     <= 1'b1;
							cur_x_q       <= start_x;
							cur_y_q       <= start_y;
							cur_heading_q <= start_heading;
							tick_q        <= '0;
							state_q       <= ST_DONE;
						end else begin
							k_q     <= K_W'(SHIFT - 1);
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (k_q == '0) begin
						state_q <= ST_FOLD_A;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_FOLD_A: begin
					state_q <= ST_FOLD_B;
				end
				ST_FOLD_B: begin
					i_q     <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (i_q == ATAN_IDX_W'(N_ITER - 1)) begin
						state_q <= ST_MUL0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_MUL0: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					cur_x_q <= sat32(sum_x);
					state_q <= ST_MUL4;
				end
				ST_MUL4: begin
					cur_y_q <= sat32(sum_y);
					state_q <= ST_MUL5;
				end
				ST_MUL5: begin
					cur_heading_q <= sat32(sum_h);
					if (tick_q != '1) begin
						tick_q <= tick_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						pos_x_q      <= cur_x_q;
						pos_y_q      <= cur_y_q;
						heading_q    <= cur_heading_q;
						tick_index_q <= tick_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign heading    = heading_q;
	assign tick_index = tick_index_q;

	// reduction leaves the angle below 2*pi
	a_reduce_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD_A) |-> (r_q < RED_W'(TWO_PI_Q30)))
		else $error("heading reduction out of range");

	// CORDIC starts inside its convergence range
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORDIC && i_q == '0) |->
		(z_q <= HALF_PI_Q30 && z_q >= -HALF_PI_Q30))
		else $error("folded angle out of range");

	// busy after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("accepted while busy");

	// a result is only produced once the start pose is loaded
	a_result_started: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> started_q)
		else $error("result before start pose");

endmodule

`default_nettype wire

[sim/drpi_checker.sv]
// ----------------------------------------------------------------------------
// drpi_checker: pose prediction and result comparison
// Watches the config port and both channels of the pose integrator. It keeps
// its own copy of the pose, the tick count and the step time. Each accepted
// odometry tick adds one predicted pose to a queue. Each accepted result is
// compared with the oldest pose in that queue.
// ----------------------------------------------------------------------------
module drpi_checker #(
	parameter int FRAC_BITS       = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [drpi_pkg::STEP_W-1:0]       cfg_wr_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [drpi_pkg::DATA_W-1:0] lin_vel,
	input  logic signed [drpi_pkg::DATA_W-1:0] ang_vel,
	input  logic signed [drpi_pkg::DATA_W-1:0] start_x,
	input  logic signed [drpi_pkg::DATA_W-1:0] start_y,
	input  logic signed [drpi_pkg::DATA_W-1:0] start_heading,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [drpi_pkg::DATA_W-1:0] pos_x,
	input  logic signed [drpi_pkg::DATA_W-1:0] pos_y,
	input  logic signed [drpi_pkg::DATA_W-1:0] heading,
	input  logic [drpi_pkg::DATA_W-1:0]        tick_index,
	output int                                fail_count,
	output int                                poses_waiting,
	output int                                poses_checked
);

	import drpi_pkg::*;

	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint TWO_PI_Q30L = 64'sd6746518852;
	localparam longint PI_Q30L     = 64'sd3373259426;
	localparam longint HALF_PI_Q30L = 64'sd1686629713;
	localparam int     TAB_LEN     = 24;
	localparam logic [STEP_W-1:0] STEP_DEFAULT = STEP_W'(((1 << FRAC_BITS) + 5) / 10);

	typedef struct packed {
		word_t             x;
		word_t             y;
		word_t             hdg;
		logic [DATA_W-1:0] idx;
	} pose_t;

	longint atan_tab [TAB_LEN];

	// predicted state of the block
	logic              pose_loaded;
	word_t             est_x;
	word_t             est_y;
	word_t             est_hdg;
	logic [DATA_W-1:0] est_ticks;
	logic [STEP_W-1:0] step_dt;

	pose_t pose_q[$];
	int    errs;
	int    checked;

	initial begin
		atan_tab = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
		};
	end

	// Shift right, rounding half away from zero
	function automatic longint round_shift(input longint v, input int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) << (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic word_t clamp_word(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return word_t'(v);
	endfunction

	// Reduce heading to [-pi/2, pi/2] in Q30, then rotate a CORDIC vector
	function automatic void heading_cos_sin(input longint hd, output longint c,
			output longint s);
		longint r;
		longint vx;
		longint vy;
		longint nx;
		bit     flip;
		int     n;
		r    = hd * (longint'(1) << (30 - FRAC_BITS));
		vx   = GAIN_Q30;
		vy   = 0;
		flip = 1'b0;
		n    = (TRIG_ITERATIONS > TAB_LEN) ? TAB_LEN : TRIG_ITERATIONS;
		r = r % TWO_PI_Q30L;
		if (r < 0) r += TWO_PI_Q30L;
		if (r > PI_Q30L) r -= TWO_PI_Q30L;
		if (r > HALF_PI_Q30L) begin
			r    -= PI_Q30L;
			flip  = 1'b1;
		end else if (r < -HALF_PI_Q30L) begin
			r    += PI_Q30L;
			flip  = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			if (r >= 0) begin
				nx  = vx - (vy >>> i);
				vy  = vy + (vx >>> i);
				r  -= atan_tab[i];
			end else begin
				nx  = vx + (vy >>> i);
				vy  = vy - (vx >>> i);
				r  += atan_tab[i];
			end
			vx = nx;
		end
		c = flip ? -vx : vx;
		s = flip ? -vy : vy;
	endfunction

	// Load the start pose on the first tick, else take one Euler step
	function automatic pose_t advance_pose(input word_t v, input word_t w,
			input word_t sx, input word_t sy, input word_t sh);
		longint c;
		longint s;
		longint tc;
		longint ts;
		longint dt;
		pose_t  p;
		dt = longint'({43'b0, step_dt});
		if (!pose_loaded) begin
			pose_loaded = 1'b1;
			est_x       = sx;
			est_y       = sy;
			est_hdg     = sh;
			est_ticks   = '0;
		end else begin
			heading_cos_sin(longint'(est_hdg), c, s);
			tc      = round_shift(longint'(v) * c, 30);
			ts      = round_shift(longint'(v) * s, 30);
			est_x   = clamp_word(longint'(est_x) + round_shift(tc * dt, FRAC_BITS));
			est_y   = clamp_word(longint'(est_y) + round_shift(ts * dt, FRAC_BITS));
			est_hdg = clamp_word(longint'(est_hdg)
				+ round_shift(longint'(w) * dt, FRAC_BITS));
			if (est_ticks != '1) est_ticks = est_ticks + 1'b1;
		end
		p.x   = est_x;
		p.y   = est_y;
		p.hdg = est_hdg;
		p.idx = est_ticks;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		if (errs < 100) begin
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		end
		errs++;
	endtask

	// Track config writes, predict on input transactions, compare on output ones
	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			pose_loaded = 1'b0;
			est_x       = '0;
			est_y       = '0;
			est_hdg     = '0;
			est_ticks   = '0;
			step_dt     = STEP_DEFAULT;
			pose_q.delete();
		end else begin
			if (cfg_wr_en) step_dt = cfg_wr_data;
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					report_mismatch("result with no pending tick", longint'(pos_x), 0);
				end else begin
					want = pose_q.pop_front();
					checked++;
					if (pos_x !== want.x)
						report_mismatch("pos_x", longint'(pos_x), longint'(want.x));
					if (pos_y !== want.y)
						report_mismatch("pos_y", longint'(pos_y), longint'(want.y));
					if (heading !== want.hdg)
						report_mismatch("heading", longint'(heading), longint'(want.hdg));
					if (tick_index !== want.idx)
						report_mismatch("tick_index", longint'({32'b0, tick_index}),
							longint'({32'b0, want.idx}));
				end
			end
			if (in_valid && in_ready) begin
				pose_q.insert(pose_q.size(), advance_pose(lin_vel, ang_vel, start_x,
					start_y, start_heading));
			end
		end
		fail_count    <= errs;
		poses_waiting <= pose_q.size();
		poses_checked <= checked;
	end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: pose integrator testbench top
// Drives odometry ticks and step-time settings into the integrator: a directed
// run over extremes, zero and STEP_MAX step time and saturation, then random
// ticks under three sender/receiver idling mixes and one long output stall.
// The checker beside the block predicts and compares each pose.
// ----------------------------------------------------------------------------
module tb;

	import drpi_pkg::*;

	localparam int FRAC_BITS       = 16;
	localparam int TRIG_ITERATIONS = 16;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int DRAIN_CYCLES    = 60;
	localparam int HOLD_CYCLES     = 400;
	localparam int BATCH_TICKS     = 50;
	localparam logic [STEP_W-1:0] STEP_MAX = 21'd1048576;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [STEP_W-1:0] cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	word_t             lin_vel;
	word_t             ang_vel;
	word_t             start_x;
	word_t             start_y;
	word_t             start_heading;
	logic              out_valid;
	logic              out_ready;
	word_t             pos_x;
	word_t             pos_y;
	word_t             heading;
	logic [DATA_W-1:0] tick_index;

	int   fail_count;
	int   poses_waiting;
	int   poses_checked;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_req;
	logic hold_taken;
	int   hold_left;
	int   ticks_sent;
	int   step_writes;

	dead_reckoning_pose_integrator_core #(
		.FRAC_BITS      (FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.lin_vel      (lin_vel),
		.ang_vel      (ang_vel),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_heading(start_heading),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.tick_index   (tick_index)
	);

	drpi_checker #(
		.FRAC_BITS      (FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.lin_vel      (lin_vel),
		.ang_vel      (ang_vel),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_heading(start_heading),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.tick_index   (tick_index),
		.fail_count   (fail_count),
		.poses_waiting(poses_waiting),
		.poses_checked(poses_checked)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	initial begin
		for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ready  = 1'b0;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_left  = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one tick, with random idle cycles first; return at the falling
	// edge after the transaction
	task automatic send_tick(input word_t v, input word_t w, input word_t sx,
			input word_t sy, input word_t sh);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		lin_vel       <= v;
		ang_vel       <= w;
		start_x       <= sx;
		start_y       <= sy;
		start_heading <= sh;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		ticks_sent++;
	endtask

	// Drain all pending poses, let the block settle, then write the step time
	task automatic set_step(input logic [STEP_W-1:0] dt);
		in_valid <= 1'b0;
		@(posedge clk);
		while (poses_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= dt;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		step_writes++;
	endtask

	// Random tick: mostly moderate velocities, some full-range and extreme ones
	task automatic send_random_tick();
		word_t v;
		word_t w;
		case ($urandom_range(0, 7))
			0: v = $urandom;
			1: v = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: v = word_t'($urandom_range(0, 1048575)) - 32'sd524288;
		endcase
		case ($urandom_range(0, 15))
			0, 1: w = $urandom;
			2: w = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: w = word_t'($urandom_range(0, 262143)) - 32'sd131072;
		endcase
		send_tick(v, w, $urandom, $urandom, $urandom);
	endtask

	// Stimulus
	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		lin_vel       = '0;
		ang_vel       = '0;
		start_x       = '0;
		start_y       = '0;
		start_heading = '0;
		hold_req      = 1'b0;
		send_idle_pct = 10;
		recv_idle_pct = 65;
		ticks_sent    = 0;
		step_writes   = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First tick loads the start pose near the position limits, facing +y
		send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFF000, 32'sh80000800, 32'sh0001921F);
		send_tick(32'sh7FFFFFFF, 32'sd0, '0, '0, '0);
		send_tick(32'sh80000000, 32'sd0, '1, '1, '1);
		send_tick(32'sh80000000, 32'sh80000000, '0, '0, '0);
		send_tick(32'sd65536, 32'sd102944, '0, '0, '0);
		send_tick(32'sd0, 32'sd0, '0, '0, '0);

		// Zero step time: pose holds while the count still rises
		set_step('0);
		send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, '0, '0, '0);
		send_tick(32'sh80000000, 32'sh80000000, '0, '0, '0);

		// Step time of STEP_MAX (16.0): heading and position saturate both ways
		set_step(STEP_MAX);
		send_tick(32'sd1, 32'sh7FFFFFFF, '0, '0, '0);
		send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, '0, '0, '0);
		send_tick(32'sh7FFFFFFF, 32'sh80000000, '0, '0, '0);
		send_tick(32'sh80000000, 32'sh80000000, '0, '0, '0);
		send_tick(32'sh80000000, 32'sd51471, '0, '0, '0);
		send_tick(32'sd1, 32'sd1, '0, '0, '0);
		send_tick(32'sh80000000, 32'sh7FFFFFFF, '0, '0, '0);

		// Smallest nonzero step: rounding of tiny increments
		set_step(21'd1);
		send_tick(32'sd32768, 32'sd32768, '0, '0, '0);
		send_tick(-32'sd32768, -32'sd32768, '0, '0, '0);
		send_tick(32'sd98304, -32'sd98303, '0, '0, '0);

		// Random ticks in three idling mixes, new step time every batch
		for (int batch = 0; batch < 9; batch++) begin
			if (batch == 3) begin
				send_idle_pct = 65;
				recv_idle_pct = 10;
			end else if (batch == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (batch % 6)
				0: set_step(21'd6554);
				1: set_step(STEP_MAX);
				2: set_step(STEP_W'($urandom_range(0, 1048576)));
				3: set_step('0);
				4: set_step(STEP_W'($urandom_range(0, 65536)));
				default: set_step(STEP_W'($urandom_range(1, 16)));
			endcase
			// Stall the output for a long stretch while ticks keep coming
			if (batch == 6) hold_req <= 1'b1;
			for (int k = 0; k < BATCH_TICKS; k++) send_random_tick();
		end
		in_valid <= 1'b0;

		// Drain
		@(posedge clk);
		while (poses_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d ticks over %0d step-time settings, %0d poses compared",
			ticks_sent, step_writes, poses_checked);
		$display("covered saturation, zero and full-scale step, idling mixes and a long stall");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
